/* rtl/core/assert_macros.svh */
// assertion macros for the predictor rtl
// no dependencies; included by tournament_branch_predictor
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is switched off while reset is high
`define TBP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds across reset
`define TBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/tbp_pkg.sv */
// types and constants of the tournament branch predictor
// no dependencies; used by tbp_update and tournament_branch_predictor
package tbp_pkg;

   // global history length limit
   localparam int unsigned HIST_W = 11;
   localparam logic [3:0] HIST_BITS_RESET = 4'd11;

   // 2-bit saturating counter values
   typedef logic [1:0] ctr_type;
   localparam ctr_type CTR_MIN       = 2'd0;
   localparam ctr_type CTR_MAX       = 2'd3;
   localparam ctr_type CTR_TAKEN_MIN = 2'd2;
   localparam ctr_type BIM_RESET     = 2'd3;
   localparam ctr_type GSH_RESET     = 2'd3;
   localparam ctr_type CHO_RESET     = 2'd0;

   // input transaction: one resolved branch
   typedef struct packed {
      logic [31:0] branch_address;
      logic        taken;
   } req_type;

   // result transaction
   typedef struct packed {
      logic        predicted_taken;
      logic        prediction_correct;
      logic        used_bimodal;
      logic [31:0] correct_count;
   } rsp_type;

   // prediction and trained counter values for one branch
   typedef struct packed {
      logic    pred;
      logic    ok;
      logic    use_bim;
      ctr_type bim_cnt;
      ctr_type gsh_cnt;
      ctr_type cho_cnt;
   } upd_type;

endpackage

/* rtl/core/tbp_update.sv */
// prediction and counter training for one resolved branch
// depends on tbp_pkg
module tbp_update (
   input  tbp_pkg::ctr_type bim_cnt,
   input  tbp_pkg::ctr_type gsh_cnt,
   input  tbp_pkg::ctr_type cho_cnt,
   input  logic             taken,
   output tbp_pkg::upd_type upd
);

   // saturating step toward the outcome
   function automatic tbp_pkg::ctr_type train(input tbp_pkg::ctr_type c, input logic t);
      tbp_pkg::ctr_type r;
      if (t) begin
         r = (c == tbp_pkg::CTR_MAX) ? c : c + 2'd1;
      end else begin
         r = (c == tbp_pkg::CTR_MIN) ? c : c - 2'd1;
      end
      return r;
   endfunction

   logic bim_pred;
   logic gsh_pred;
   logic bim_ok;
   logic gsh_ok;

   // individual predictions
   assign bim_pred = (bim_cnt >= tbp_pkg::CTR_TAKEN_MIN);
   assign gsh_pred = (gsh_cnt >= tbp_pkg::CTR_TAKEN_MIN);
   assign bim_ok   = (bim_pred == taken);
   assign gsh_ok   = (gsh_pred == taken);

   // chosen prediction and trained counters
   always_comb begin
      upd.use_bim = (cho_cnt >= tbp_pkg::CTR_TAKEN_MIN);
      upd.pred    = upd.use_bim ? bim_pred : gsh_pred;
      upd.ok      = (upd.pred == taken);
      upd.bim_cnt = train(bim_cnt, taken);
      upd.gsh_cnt = train(gsh_cnt, taken);
      if (gsh_ok && !bim_ok) begin
         upd.cho_cnt = train(cho_cnt, 1'b0);
      end else if (bim_ok && !gsh_ok) begin
         upd.cho_cnt = train(cho_cnt, 1'b1);
      end else begin
         upd.cho_cnt = cho_cnt;
      end
   end

endmodule

/* rtl/core/tournament_branch_predictor.sv */
// Tournament branch predictor: bimodal and gshare tables with a per-address chooser.
// Each req transaction carries one resolved branch (address, taken); each one
// produces exactly one rsp transaction with the prediction made before training,
// whether it was right, which table was chosen and the saturating hit count.
// The csr channel writes history_bits (0..15, lengths above 11 act as 11);
// csr_ready is always high, writes are meant for idle periods.
// An accepted transaction passes through the read stage, then the result register.
// Throughput: one branch per cycle when neither clearing nor rsp_stall holds it.
// Each item reads both memories in its accept cycle and writes them back when it
// leaves the read stage; a write to the entry that the following branch reads
// is forwarded around the memory.
// Reset (synchronous, active high) clears history and hit count, sets
// history_bits to 11, then a clearing pass writes every table entry;
// req_stall stays high during that pass.
// When rsp_stall is high the result register holds; the item behind it waits
// in the read stage and req_stall rises until the result is taken.
// TABLE_ENTRIES must be a power of two (16..65536).
// Depends on tbp_pkg, tbp_update and assert_macros.svh.
`include "assert_macros.svh"

module tournament_branch_predictor #(
   parameter int unsigned TABLE_ENTRIES = 2048
) (
   input  logic             clock,
   input  logic             reset,
   // branch input
   input  logic             req_valid,
   output logic             req_stall,
   input  tbp_pkg::req_type req_data,
   // result output
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tbp_pkg::rsp_type rsp_data,
   // history length register
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [3:0]       csr_data
);

   localparam int unsigned IW = $clog2(TABLE_ENTRIES);
   localparam int unsigned XW = (IW > tbp_pkg::HIST_W) ? IW : tbp_pkg::HIST_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

   // table memories: {chooser, bimodal} by address, gshare by hashed index
   logic [3:0] bc_mem [TABLE_ENTRIES];
   logic [1:0] gs_mem [TABLE_ENTRIES];

   logic                  clear_ff, clear_in;
   logic [IW-1:0]         clr_idx_ff, clr_idx_in;
   logic [3:0]            hist_bits_ff, hist_bits_in;
   logic [tbp_pkg::HIST_W-1:0] hist_ff, hist_in;
   logic [31:0]           hit_ff, hit_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic [IW-1:0]         s1_bi_ff;
   logic [IW-1:0]         s1_gi_ff;
   logic                  s1_taken_ff;
   logic [3:0]            bc_rd_ff;
   logic [1:0]            gs_rd_ff;
   logic                  fwd_bc_ff;
   logic                  fwd_gs_ff;
   logic [3:0]            fwd_bc_val_ff;
   logic [1:0]            fwd_gs_val_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   tbp_pkg::rsp_type      rsp_ff;

   logic                  req_fire;
   logic                  s1_fire;
   logic [3:0]            eff_len;
   logic [tbp_pkg::HIST_W-1:0] hist_mask;
   logic [tbp_pkg::HIST_W-1:0] hist_used;
   logic [XW-1:0]         hash_w;
   logic [IW-1:0]         req_bi;
   logic [IW-1:0]         req_gi;
   logic [3:0]            bc_cur;
   logic [1:0]            gs_cur;
   tbp_pkg::upd_type      upd;

   // handshakes
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clear_ff || (s1_valid_ff && !s1_fire);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // history mask, lengths above the limit act as the limit
   always_comb begin
      eff_len   = (hist_bits_ff > 4'(tbp_pkg::HIST_W)) ? 4'(tbp_pkg::HIST_W) : hist_bits_ff;
      hist_mask = tbp_pkg::HIST_W'((12'd1 << eff_len) - 12'd1);
      hist_used = hist_ff & hist_mask;
   end

   // table indexes of the incoming branch
   always_comb begin
      req_bi = req_data.branch_address[IW-1:0];
      hash_w = XW'(req_bi) ^ XW'(hist_used);
      req_gi = hash_w[IW-1:0];
   end

   // counters of the branch in the read stage, with forwarding
   assign bc_cur = fwd_bc_ff ? fwd_bc_val_ff : bc_rd_ff;
   assign gs_cur = fwd_gs_ff ? fwd_gs_val_ff : gs_rd_ff;

   tbp_update u_update (
      .bim_cnt (bc_cur[1:0]),
      .gsh_cnt (gs_cur),
      .cho_cnt (bc_cur[3:2]),
      .taken   (s1_taken_ff),
      .upd     (upd)
   );

   // next state of control and counters
   always_comb begin
      clear_in   = clear_ff;
      clr_idx_in = clr_idx_ff;
      if (clear_ff) begin
         clr_idx_in = clr_idx_ff + IW'(1);
         if (clr_idx_ff == LAST_IDX) begin
            clear_in = 1'b0;
         end
      end
      hist_bits_in = csr_valid ? csr_data : hist_bits_ff;
      hist_in = req_fire ? ({hist_ff[tbp_pkg::HIST_W-2:0], req_data.taken} & hist_mask)
                         : hist_ff;
      hit_in = (s1_fire && upd.ok && (hit_ff != 32'hFFFF_FFFF)) ? hit_ff + 32'd1 : hit_ff;
      s1_valid_in = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_stall) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clr_idx_ff   <= '0;
         hist_bits_ff <= tbp_pkg::HIST_BITS_RESET;
         hist_ff      <= '0;
         hit_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         clr_idx_ff   <= clr_idx_in;
         hist_bits_ff <= hist_bits_in;
         hist_ff      <= hist_in;
         hit_ff       <= hit_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // read stage payload and forwarding of the concurrent write back
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_bi_ff      <= req_bi;
         s1_gi_ff      <= req_gi;
         s1_taken_ff   <= req_data.taken;
         fwd_bc_ff     <= s1_fire && (req_bi == s1_bi_ff);
         fwd_gs_ff     <= s1_fire && (req_gi == s1_gi_ff);
         fwd_bc_val_ff <= {upd.cho_cnt, upd.bim_cnt};
         fwd_gs_val_ff <= upd.gsh_cnt;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_ff.predicted_taken    <= upd.pred;
         rsp_ff.prediction_correct <= upd.ok;
         rsp_ff.used_bimodal       <= upd.use_bim;
         rsp_ff.correct_count      <= hit_in;
      end
   end

   // table memories: clearing pass or write back, read on accept
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         bc_mem[clr_idx_ff] <= {tbp_pkg::CHO_RESET, tbp_pkg::BIM_RESET};
         gs_mem[clr_idx_ff] <= tbp_pkg::GSH_RESET;
      end else if (s1_fire) begin
         bc_mem[s1_bi_ff] <= {upd.cho_cnt, upd.bim_cnt};
         gs_mem[s1_gi_ff] <= upd.gsh_cnt;
      end
      if (req_fire) begin
         bc_rd_ff <= bc_mem[req_bi];
         gs_rd_ff <= gs_mem[req_gi];
      end
   end

   // checks
   `TBP_ASSERT_ALWAYS(a_reset_starts_clear, clock,
      reset |=> (clear_ff && (clr_idx_ff == '0) && !s1_valid_ff), "clear pass not started")
   `TBP_ASSERT(a_stage_holds, clock, reset,
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |=> (s1_valid_ff && $stable(s1_bi_ff)),
      "read stage lost an item while output blocked")
   `TBP_ASSERT(a_rsp_from_stage, clock, reset,
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff), "result without an item in flight")
   `TBP_ASSERT(a_fwd_only_on_overlap, clock, reset,
      (fwd_bc_ff && $past(req_fire)) |-> $past(s1_fire), "forward flag without write back")

endmodule
